@@ sv/crfb_pkg.sv @@
// ---------------------------------------------------------------------------
// crfb_pkg
// Panel geometry, derived widths, request codes and address helper for the
// clipped rectangle fill and blit framebuffer core.
// ---------------------------------------------------------------------------
package crfb_pkg;

	localparam int PANEL_WIDTH  = 320;
	localparam int PANEL_HEIGHT = 240;
	localparam int PANEL_PIXELS = PANEL_WIDTH * PANEL_HEIGHT;

	// Column, row and linear address widths
	localparam int XW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
	localparam int YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
	localparam int AW = (PANEL_PIXELS > 1) ? $clog2(PANEL_PIXELS) : 1;

	localparam int PIX_W = 16;
	localparam int CNT_W = 19;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [AW-1:0]    addr_t;
	typedef logic [XW-1:0]    col_t;
	typedef logic [YW-1:0]    row_t;

	typedef enum logic [2:0] {
		REQ_CLEAR = 3'd0,
		REQ_FILL  = 3'd1,
		REQ_BLIT  = 3'd2,
		REQ_READ  = 3'd3,
		REQ_COUNT = 3'd4
	} req_code_t;

	function automatic addr_t pix_addr(input col_t c, input row_t r);
		return AW'(r) * AW'(PANEL_WIDTH) + AW'(c);
	endfunction

endpackage

@@ sv/clipped_rect_fill_blit_framebuffer_core.sv @@
// Results: blit, empty fill and unused codes load the result register at the
// transfer; read passes through ST_READ1 and ST_READ2; fill and clear load it at
// the last pixel of their walk, count after the ST_CTAIL compare stage.
// Throughput: one request in flight; the single write and read port of the panel
// memory walks one pixel per cycle for fill, clear and count.
// Reset: a clearing pass over all PANEL_PIXELS (76800) pixels zeroes the panel first.
// ---------------------------------------------------------------------------
// clipped_rect_fill_blit_framebuffer_core
// RGB565 panel memory with clear, clipped fill, streaming blit, pixel read
// and colour count requests.
// ---------------------------------------------------------------------------
module clipped_rect_fill_blit_framebuffer_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [2:0]             req_type,
	input  logic signed [15:0]     rect_x,
	input  logic signed [15:0]     rect_y,
	input  logic signed [15:0]     rect_w,
	input  logic signed [15:0]     rect_h,
	input  logic [15:0]            pixel_value,
	input  logic                   first_pixel,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [15:0]            read_pixel,
	output logic [crfb_pkg::CNT_W-1:0] color_count,
	output logic                   pixel_written
);
	import crfb_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILL  = 3'd1;
	localparam logic [2:0] ST_READ1 = 3'd2;
	localparam logic [2:0] ST_READ2 = 3'd3;
	localparam logic [2:0] ST_COUNT = 3'd4;
	localparam logic [2:0] ST_CTAIL = 3'd5;

	localparam logic signed [17:0] W_S = 18'(PANEL_WIDTH);
	localparam logic signed [17:0] H_S = 18'(PANEL_HEIGHT);
	localparam col_t  COL_LAST  = XW'(PANEL_WIDTH - 1);
	localparam row_t  ROW_LAST  = YW'(PANEL_HEIGHT - 1);
	localparam addr_t ADDR_LAST = AW'(PANEL_PIXELS - 1);

	logic [2:0]  state_q;
	logic        init_q;
	pixel_t      pix_q;
	col_t        col_q, x_first_q, x_last_q;
	row_t        row_q, y_last_q;
	logic [15:0] blit_col_q, blit_row_q;
	addr_t       rd_addr_q;
	logic        rd_on_q;
	pixel_t      rd_q;
	logic        cmp_vld_s1, cmp_last_s1;
	logic [CNT_W-1:0] cnt_q;

	logic        wr_en_s1;
	addr_t       wr_addr_s1;
	pixel_t      wr_data_s1;

	logic        rsp_valid_q;
	pixel_t      read_pixel_q;
	logic [CNT_W-1:0] color_count_q;
	logic        pixel_written_q;

	pixel_t      panel_mem [PANEL_PIXELS];

	logic        accept;
	logic signed [17:0] xs, ys, ws, hs, xe, ye;
	logic signed [17:0] x0, y0, x1, y1, x1m, y1m;
	logic        fill_hit;
	logic [15:0] colv, rowv;
	logic signed [17:0] tx, ty;
	logic        blit_act, blit_in, blit_on, blit_wrap;
	logic        rd_on;
	logic        fill_col_end, fill_row_end;
	logic        match;
	logic [CNT_W-1:0] cnt_next;
	logic        load_out;

	assign req_stall = !((state_q == ST_IDLE) && (!rsp_valid_q || !rsp_stall));
	assign accept    = req_valid && !req_stall;

	// Operand decode and clipping
	always_comb begin
		xs  = $signed({{2{rect_x[15]}}, rect_x});
		ys  = $signed({{2{rect_y[15]}}, rect_y});
		ws  = $signed({{2{rect_w[15]}}, rect_w});
		hs  = $signed({{2{rect_h[15]}}, rect_h});
		xe  = xs + ws;
		ye  = ys + hs;
		x0  = (xs < 0) ? 18'sd0 : xs;
		y0  = (ys < 0) ? 18'sd0 : ys;
		x1  = (xe > W_S) ? W_S : xe;
		y1  = (ye > H_S) ? H_S : ye;
		x1m = x1 - 18'sd1;
		y1m = y1 - 18'sd1;
		fill_hit = (ws > 0) && (hs > 0) && (x0 < x1) && (y0 < y1);

		colv = first_pixel ? 16'd0 : blit_col_q;
		rowv = first_pixel ? 16'd0 : blit_row_q;
		tx   = xs + $signed({2'b00, colv});
		ty   = ys + $signed({2'b00, rowv});
		blit_act  = (ws > 0) && (hs > 0) && (rowv < rect_h[15:0]);
		blit_in   = blit_act && (colv < rect_w[15:0]);
		blit_on   = (tx >= 0) && (tx < W_S) && (ty >= 0) && (ty < H_S);
		blit_wrap = ({1'b0, colv} + 17'd1) >= {1'b0, rect_w[15:0]};

		rd_on = (xs >= 0) && (xs < W_S) && (ys >= 0) && (ys < H_S);

		fill_col_end = (col_q == x_last_q);
		fill_row_end = (row_q == y_last_q);

		match    = (rd_q == pix_q);
		cnt_next = cnt_q + CNT_W'(match);
	end

	// Panel memory: one write port fed by the write stage, one registered read
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			panel_mem[wr_addr_s1] <= wr_data_s1;
		end
		rd_q <= panel_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q      <= 1'b1;
			pix_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			x_first_q   <= '0;
			x_last_q    <= COL_LAST;
			y_last_q    <= ROW_LAST;
			blit_col_q  <= '0;
			blit_row_q  <= '0;
			rd_addr_q   <= '0;
			rd_on_q     <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			cnt_q       <= '0;
			wr_en_s1    <= 1'b0;
			wr_addr_s1  <= '0;
			wr_data_s1  <= '0;
		end else begin
			wr_en_s1    <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
			if (cmp_vld_s1) begin
				cnt_q <= cnt_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						init_q <= 1'b0;
						case (req_type)
							REQ_CLEAR: begin
								pix_q     <= '0;
								col_q     <= '0;
								row_q     <= '0;
								x_first_q <= '0;
								x_last_q  <= COL_LAST;
								y_last_q  <= ROW_LAST;
								state_q   <= ST_FILL;
							end
							REQ_FILL: begin
								if (fill_hit) begin
									pix_q     <= pixel_value;
									col_q     <= x0[XW-1:0];
									row_q     <= y0[YW-1:0];
									x_first_q <= x0[XW-1:0];
									x_last_q  <= x1m[XW-1:0];
									y_last_q  <= y1m[YW-1:0];
									state_q   <= ST_FILL;
								end
							end
							REQ_BLIT: begin
								if (blit_in && blit_on) begin
									wr_en_s1   <= 1'b1;
									wr_addr_s1 <= pix_addr(tx[XW-1:0], ty[YW-1:0]);
									wr_data_s1 <= pixel_value;
								end
								// advance the walk while active, else hold its position
								if (blit_act && blit_wrap) begin
									blit_col_q <= '0;
									blit_row_q <= rowv + 16'd1;
								end else if (blit_act) begin
									blit_col_q <= colv + 16'd1;
									blit_row_q <= rowv;
								end else begin
									blit_col_q <= colv;
									blit_row_q <= rowv;
								end
							end
							REQ_READ: begin
								rd_on_q <= rd_on;
								if (rd_on) begin
									rd_addr_q <= pix_addr(xs[XW-1:0], ys[YW-1:0]);
								end
								state_q <= ST_READ1;
							end
							REQ_COUNT: begin
								pix_q     <= pixel_value;
								rd_addr_q <= '0;
								cnt_q     <= '0;
								state_q   <= ST_COUNT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= pix_addr(col_q, row_q);
					wr_data_s1 <= pix_q;
					if (fill_col_end) begin
						col_q <= x_first_q;
						if (fill_row_end) begin
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + YW'(1);
						end
					end else begin
						col_q <= col_q + XW'(1);
					end
				end
				ST_READ1: begin
					state_q <= ST_READ2;
				end
				ST_READ2: begin
					state_q <= ST_IDLE;
				end
				ST_COUNT: begin
					cmp_vld_s1  <= 1'b1;
					cmp_last_s1 <= (rd_addr_q == ADDR_LAST);
					if (rd_addr_q == ADDR_LAST) begin
						state_q <= ST_CTAIL;
					end else begin
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
				ST_CTAIL: begin
					if (cmp_last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_comb begin
		load_out = 1'b0;
		if (accept && ((req_type == REQ_BLIT) || (req_type == REQ_READ) == 1'b0 &&
				(req_type != REQ_CLEAR) && (req_type != REQ_COUNT) &&
				!((req_type == REQ_FILL) && fill_hit))) begin
			load_out = 1'b1;
		end
		if ((state_q == ST_FILL) && fill_col_end && fill_row_end && !init_q) begin
			load_out = 1'b1;
		end
		if (state_q == ST_READ2) begin
			load_out = 1'b1;
		end
		if ((state_q == ST_CTAIL) && cmp_last_s1) begin
			load_out = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			read_pixel_q    <= '0;
			color_count_q   <= '0;
			pixel_written_q <= 1'b0;
			if (state_q == ST_FILL) begin
				pixel_written_q <= 1'b1;
			end else if (state_q == ST_READ2) begin
				read_pixel_q <= rd_on_q ? rd_q : '0;
			end else if (state_q == ST_CTAIL) begin
				color_count_q <= cnt_next;
			end else if (req_type == REQ_BLIT) begin
				pixel_written_q <= blit_in && blit_on;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign read_pixel    = read_pixel_q;
	assign color_count   = color_count_q;
	assign pixel_written = pixel_written_q;

	// Result slot is free whenever a result is loaded
	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(rsp_valid_q && rsp_stall))
		else $error("result loaded over a stalled result");

	// No memory write may be pending while a read or count is reading
	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ1 || state_q == ST_COUNT) |-> !wr_en_s1)
		else $error("write pending during panel read");

	a_wr_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> (wr_addr_s1 <= ADDR_LAST))
		else $error("panel write address out of range");

	a_fill_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> ((col_q <= x_last_q) && (row_q <= y_last_q)))
		else $error("fill cursor outside clipped rectangle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PANEL_PIXELS))
		else $error("colour count exceeds panel size");

endmodule

@@ test/clipped_rect_fill_blit_framebuffer_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_rect_fill_blit_framebuffer_core_test
// Drives clear, fill, blit, read and count requests into the panel core.
// The test starts with a short table of edge cases, then runs random
// requests, mostly well-formed blit runs. A local copy of the panel predicts
// every response but those of table rows with fixed expectations, and each
// response is checked field by field. Random gaps are inserted on both sides,
// with one long response hold-off and one drain pause.
// ---------------------------------------------------------------------------
module clipped_rect_fill_blit_framebuffer_core_test;
	import crfb_pkg::*;

	localparam bit [2:0] REQ_SPARE5 = 3'd5;
	localparam bit [2:0] REQ_SPARE6 = 3'd6;
	localparam bit [2:0] REQ_SPARE7 = 3'd7;
	localparam int DIR_ROWS     = 29;
	localparam int RAND_ITEMS   = 900;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_LINES    = 30;

	typedef struct {
		bit [2:0]  kind;
		shortint   x;
		shortint   y;
		shortint   w;
		shortint   h;
		bit [15:0] pix;
		bit        first;
	} panel_req_t;

	typedef struct packed {
		bit [15:0]      pix_rd;
		bit [CNT_W-1:0] match_cnt;
		bit             wrote;
	} panel_rsp_t;

	typedef struct {
		bit [2:0]  kind;
		shortint   x;
		shortint   y;
		shortint   w;
		shortint   h;
		bit [15:0] pix;
		bit        first;
		bit        fixed;
		bit [15:0] rd;
		int        cnt;
		bit        wr;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [2:0]            req_type = '0;
	logic signed [15:0]    rect_x = '0;
	logic signed [15:0]    rect_y = '0;
	logic signed [15:0]    rect_w = '0;
	logic signed [15:0]    rect_h = '0;
	logic [15:0]           pixel_value = '0;
	logic                  first_pixel = 1'b0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [15:0]           read_pixel;
	logic [CNT_W-1:0]      color_count;
	logic                  pixel_written;

	bit [15:0]  panel_img [PANEL_PIXELS];
	bit [15:0]  walk_col;
	bit [15:0]  walk_row;
	panel_rsp_t due_results [$];
	int         mismatches;
	int         tx_count;
	int         rsp_seen;
	dir_row_t   dir_tab [DIR_ROWS];

	always #2 clk = ~clk;

	clipped_rect_fill_blit_framebuffer_core uut (.*);

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_LINES) begin
			$display("tb: mismatch on %s: got %0h want %0h at %0t", what, got, want, $time);
		end
	endtask

	task automatic apply_to_panel(input panel_req_t rq, output panel_rsp_t res);
		int xi, yi, wi, hi;
		int x0, y0, x1, y1;
		int tx, ty;
		xi = rq.x;
		yi = rq.y;
		wi = rq.w;
		hi = rq.h;
		res = '0;
		case (rq.kind)
			REQ_CLEAR: begin
				foreach (panel_img[i]) panel_img[i] = '0;
				res.wrote = 1'b1;
			end
			REQ_FILL: begin
				if (wi > 0 && hi > 0) begin
					x0 = (xi < 0) ? 0 : xi;
					y0 = (yi < 0) ? 0 : yi;
					x1 = (xi + wi > PANEL_WIDTH) ? PANEL_WIDTH : xi + wi;
					y1 = (yi + hi > PANEL_HEIGHT) ? PANEL_HEIGHT : yi + hi;
					if (x0 < x1 && y0 < y1) begin
						for (int ry = y0; ry < y1; ry++) begin
							for (int cx = x0; cx < x1; cx++) begin
								panel_img[ry * PANEL_WIDTH + cx] = rq.pix;
							end
						end
						res.wrote = 1'b1;
					end
				end
			end
			REQ_BLIT: begin
				if (rq.first) begin
					walk_col = '0;
					walk_row = '0;
				end
				if (wi > 0 && hi > 0 && int'(walk_row) < hi) begin
					if (int'(walk_col) < wi) begin
						tx = xi + int'(walk_col);
						ty = yi + int'(walk_row);
						if (tx >= 0 && ty >= 0 && tx < PANEL_WIDTH && ty < PANEL_HEIGHT) begin
							panel_img[ty * PANEL_WIDTH + tx] = rq.pix;
							res.wrote = 1'b1;
						end
					end
					// wrap to the next row at the end of the current width
					if (int'(walk_col) + 1 >= wi) begin
						walk_col = '0;
						walk_row = walk_row + 16'd1;
					end else begin
						walk_col = walk_col + 16'd1;
					end
				end
			end
			REQ_READ: begin
				if (xi >= 0 && yi >= 0 && xi < PANEL_WIDTH && yi < PANEL_HEIGHT) begin
					res.pix_rd = panel_img[yi * PANEL_WIDTH + xi];
				end
			end
			REQ_COUNT: begin
				foreach (panel_img[i]) begin
					if (panel_img[i] == rq.pix) res.match_cnt = res.match_cnt + 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// Hold the request until its transfer, then draw the gap before the next one.
	task automatic send_req(input panel_req_t rq, input bit fixed, input panel_rsp_t want);
		panel_rsp_t predicted;
		int gap;
		req_valid   <= 1'b1;
		req_type    <= rq.kind;
		rect_x      <= rq.x;
		rect_y      <= rq.y;
		rect_w      <= rq.w;
		rect_h      <= rq.h;
		pixel_value <= rq.pix;
		first_pixel <= rq.first;
		do @(posedge clk); while (req_stall !== 1'b0);
		apply_to_panel(rq, predicted);
		due_results.push_back(fixed ? want : predicted);
		tx_count++;
		gap = (((tx_count / 64) % 4) == 1) ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		panel_req_t rq;
		panel_rsp_t want;
		int n, pick, len, cols, rows, heavy, last_x, last_y;
		bit paused;
		bit [15:0] hot_pix;
		shortint bx, by;

		dir_tab = '{
			'{REQ_READ,   0,      0,      0,      0,     16'h0000, 1'b0, 1'b1, 16'h0000, 76800 * 0, 1'b0},
			'{REQ_COUNT,  0,      0,      0,      0,     16'h0000, 1'b0, 1'b1, 16'h0000, 76800, 1'b0},
			'{REQ_FILL,   -32768, -32768, 32767,  32767, 16'h1234, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_FILL,   10,     10,     0,      5,     16'h1234, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_FILL,   10,     10,     -32768, -1,    16'h1234, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_FILL,   320,    0,      5,      5,     16'h1234, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_FILL,   0,      240,    5,      5,     16'h1234, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_FILL,   -4,     -4,     32767,  32767, 16'hFFFF, 1'b0, 1'b1, 16'h0000, 0, 1'b1},
			'{REQ_READ,   319,    239,    0,      0,     16'h0000, 1'b0, 1'b1, 16'hFFFF, 0, 1'b0},
			'{REQ_READ,   320,    0,      0,      0,     16'h0000, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_READ,   -1,     -1,     0,      0,     16'h0000, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_COUNT,  0,      0,      0,      0,     16'hFFFF, 1'b0, 1'b1, 16'h0000, 76800, 1'b0},
			'{REQ_CLEAR,  -1,     -1,     -1,     -1,    16'hFFFF, 1'b1, 1'b1, 16'h0000, 0, 1'b1},
			'{REQ_FILL,   318,    238,    8,      8,     16'hF800, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   319,    239,    2,      2,     16'h001F, 1'b1, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   319,    239,    2,      2,     16'h07E0, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   319,    239,    2,      2,     16'h07E0, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   319,    239,    2,      2,     16'h07E0, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   319,    239,    2,      2,     16'hFFFF, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   5,      5,      0,      3,     16'hFFFF, 1'b1, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   100,    100,    4,      2,     16'hABCD, 1'b1, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   100,    100,    1,      2,     16'h1357, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_BLIT,   100,    100,    1,      2,     16'h2468, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_READ,   100,    101,    0,      0,     16'h0000, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_READ,   319,    239,    0,      0,     16'h0000, 1'b0, 1'b0, 16'h0000, 0, 1'b0},
			'{REQ_SPARE5, 32767,  -32768, 32767,  32767, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_SPARE6, -1,     -1,     -1,     -1,    16'hFFFF, 1'b1, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_SPARE7, 0,      0,      1,      1,     16'h0000, 1'b0, 1'b1, 16'h0000, 0, 1'b0},
			'{REQ_COUNT,  0,      0,      0,      0,     16'hF800, 1'b0, 1'b0, 16'h0000, 0, 1'b0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			rq = '{dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].w, dir_tab[i].h,
				dir_tab[i].pix, dir_tab[i].first};
			want = '{dir_tab[i].rd, CNT_W'(dir_tab[i].cnt), dir_tab[i].wr};
			send_req(rq, dir_tab[i].fixed, want);
		end

		n = 0;
		heavy = 0;
		paused = 1'b0;
		hot_pix = 16'hF800;
		last_x = 100;
		last_y = 100;
		while (n < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (heavy < 3 && n >= 250 * (heavy + 1)) begin
				// full-panel walks are slow: count, clear, count once each
				rq = '{REQ_COUNT, shortint'($urandom), shortint'($urandom), shortint'($urandom),
					shortint'($urandom), hot_pix, 1'($urandom)};
				if (heavy == 1) rq.kind = REQ_CLEAR;
				if (heavy == 2) rq.pix = 16'h0000;
				heavy++;
				n++;
				send_req(rq, 1'b0, '0);
			end else if (!paused && n >= 450) begin
				// drain everything before going on
				req_valid <= 1'b0;
				do @(posedge clk); while (due_results.size() != 0);
				paused = 1'b1;
			end else if (pick < 45) begin
				cols = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
				rows = (cols > 6) ? $urandom_range(1, 2) : $urandom_range(1, 4);
				bx = shortint'(int'($urandom_range(0, 335)) - 8);
				by = shortint'(int'($urandom_range(0, 255)) - 8);
				len = cols * rows;
				// cut some runs short and overrun others
				case ($urandom_range(0, 7))
					0: len = $urandom_range(1, len);
					1: len = len + $urandom_range(1, 3);
					default: ;
				endcase
				for (int k = 0; k < len; k++) begin
					rq = '{REQ_BLIT, bx, by, shortint'(cols), shortint'(rows), 16'($urandom),
						k == 0};
					send_req(rq, 1'b0, '0);
				end
				hot_pix = rq.pix;
				last_x = bx;
				last_y = by;
				n += len;
			end else if (pick < 65) begin
				rq = '{REQ_READ, 0, 0, shortint'($urandom), shortint'($urandom), 16'($urandom),
					1'($urandom)};
				case ($urandom_range(0, 3))
					0: begin
						rq.x = shortint'($urandom);
						rq.y = shortint'($urandom);
					end
					1: begin
						rq.x = shortint'($urandom_range(0, PANEL_WIDTH - 1));
						rq.y = shortint'($urandom_range(0, PANEL_HEIGHT - 1));
					end
					default: begin
						rq.x = shortint'(last_x + int'($urandom_range(0, 7)));
						rq.y = shortint'(last_y + int'($urandom_range(0, 3)));
					end
				endcase
				n++;
				send_req(rq, 1'b0, '0);
			end else if (pick < 90) begin
				rq = '{REQ_FILL, shortint'(int'($urandom_range(0, 335)) - 8),
					shortint'(int'($urandom_range(0, 255)) - 8),
					shortint'(int'($urandom_range(0, 13)) - 1),
					shortint'(int'($urandom_range(0, 13)) - 1), 16'($urandom), 1'($urandom)};
				if (pick >= 80 && pick < 85) begin
					rq.w = shortint'($urandom_range(1, 80));
					rq.h = shortint'($urandom_range(1, 60));
				end else if (pick >= 85) begin
					// one wild field, the others keep the clipped area small
					case ($urandom_range(0, 3))
						0: rq.x = shortint'($urandom);
						1: rq.y = shortint'($urandom);
						2: begin
							rq.w = shortint'($urandom);
							rq.x = shortint'($urandom_range(PANEL_WIDTH - 8, PANEL_WIDTH - 1));
						end
						default: begin
							rq.h = shortint'($urandom);
							rq.y = shortint'($urandom_range(PANEL_HEIGHT - 8, PANEL_HEIGHT - 1));
						end
					endcase
				end
				hot_pix = rq.pix;
				last_x = (rq.x < 0) ? 0 : rq.x;
				last_y = (rq.y < 0) ? 0 : rq.y;
				n++;
				send_req(rq, 1'b0, '0);
			end else if (pick < 97) begin
				rq = '{REQ_BLIT, shortint'($urandom), shortint'($urandom), shortint'($urandom),
					shortint'($urandom), 16'($urandom), 1'($urandom)};
				if ($urandom_range(0, 1) == 0) begin
					rq.x = shortint'(int'($urandom_range(0, 335)) - 8);
					rq.y = shortint'(int'($urandom_range(0, 255)) - 8);
					rq.w = shortint'(int'($urandom_range(0, 5)) - 2);
					rq.h = shortint'(int'($urandom_range(0, 5)) - 2);
				end
				n++;
				send_req(rq, 1'b0, '0);
			end else begin
				rq = '{3'($urandom_range(REQ_SPARE5, REQ_SPARE7)), shortint'($urandom),
					shortint'($urandom), shortint'($urandom), shortint'($urandom),
					16'($urandom), 1'($urandom)};
				send_req(rq, 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Response side: check each transfer, then hold off for a drawn number of cycles.
	initial begin
		panel_rsp_t want;
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				rsp_seen++;
				if (due_results.size() == 0) begin
					note_mismatch("unexpected response", 32'(read_pixel), 0);
				end else begin
					want = due_results.pop_front();
					if (read_pixel !== want.pix_rd) begin
						note_mismatch("read_pixel", 32'(read_pixel), 32'(want.pix_rd));
					end
					if (color_count !== want.match_cnt) begin
						note_mismatch("color_count", 32'(color_count), 32'(want.match_cnt));
					end
					if (pixel_written !== want.wrote) begin
						note_mismatch("pixel_written", 32'(pixel_written), 32'(want.wrote));
					end
				end
				hold = (((rsp_seen / 50) % 4) == 2) ? 0 : $urandom_range(0, 15);
				// back up the core once while requests keep coming
				if (rsp_seen == 300) hold = LONG_HOLD;
				if (hold != 0) begin
					rsp_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/crfb_pkg.sv
sv/clipped_rect_fill_blit_framebuffer_core.sv
test/clipped_rect_fill_blit_framebuffer_core_test.sv
